### src/bhc_pkg.sv
// Shared types, constants and tables of the hall commutation block.
package bhc_pkg;

  localparam int PwmBits        = 8;
  localparam int SineFracBits   = 15;
  localparam int ErrCountBits   = 16;
  localparam int AngleBits      = 9;
  localparam int HallBits       = 3;
  localparam int QuarterEntries = 91;
  localparam int SineIdxBits    = $clog2(QuarterEntries);

  localparam logic [63:0] RadPerDegQ30 = 64'd18740330;

  // Item kinds.
  localparam logic KindHall  = 1'b0;
  localparam logic KindAngle = 1'b1;

  // Valid hall codes in rotation order.
  localparam logic [HallBits-1:0] Hall000 = 3'b100;
  localparam logic [HallBits-1:0] Hall060 = 3'b110;
  localparam logic [HallBits-1:0] Hall120 = 3'b010;
  localparam logic [HallBits-1:0] Hall180 = 3'b011;
  localparam logic [HallBits-1:0] Hall240 = 3'b001;
  localparam logic [HallBits-1:0] Hall300 = 3'b101;

  // Configuration register indexes.
  localparam logic [1:0] RegDuty      = 2'd0;
  localparam logic [1:0] RegDirection = 2'd1;
  localparam logic [1:0] RegSineMode  = 2'd2;

  // Phase indexes.
  localparam logic [1:0] PhU = 2'd0;
  localparam logic [1:0] PhV = 2'd1;
  localparam logic [1:0] PhW = 2'd2;

  localparam logic [2:0] EnUV = 3'b011;
  localparam logic [2:0] EnUW = 3'b101;
  localparam logic [2:0] EnVW = 3'b110;
  localparam logic [2:0] EnAll = 3'b111;

  typedef logic [2:0][PwmBits-1:0] cmp_arr_t;

  typedef struct packed {
    logic [AngleBits-1:0]    angle;
    logic [HallBits-1:0]     code;
    logic                    err;
    logic [ErrCountBits-1:0] count;
  } upd_t;

  typedef struct packed {
    logic [2:0] en;
    logic [1:0] hi;
    logic [1:0] lo;
  } step_t;

  typedef logic [SineFracBits-1:0] sine_tab_t [QuarterEntries];

  // Quarter-wave sine in Q0.15 built at elaboration from a Q30 Taylor series.
  function automatic logic [SineFracBits-1:0] quarter_sine(input int unsigned d);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        r;
    x    = 64'(d) * RadPerDegQ30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    r = (unsigned'(sum) + (64'd1 << (29 - SineFracBits))) >> (30 - SineFracBits);
    if (r > (64'd1 << SineFracBits) - 64'd1) begin
      r = (64'd1 << SineFracBits) - 64'd1;
    end
    return r[SineFracBits-1:0];
  endfunction

  function automatic sine_tab_t build_sine_table();
    sine_tab_t t;
    for (int d = 0; d < QuarterEntries; d++) begin
      t[d] = quarter_sine(d);
    end
    return t;
  endfunction

  localparam sine_tab_t SineTable = build_sine_table();

  // Six-step commutation table: enables, phase driven to duty, phase driven low.
  function automatic step_t step_entry(input logic fwd, input logic [2:0] sector);
    step_t e;
    if (fwd) begin
      case (sector)
        3'd0:    e = '{en: EnUW, hi: PhU, lo: PhW};
        3'd1:    e = '{en: EnVW, hi: PhV, lo: PhW};
        3'd2:    e = '{en: EnUV, hi: PhV, lo: PhU};
        3'd3:    e = '{en: EnUW, hi: PhW, lo: PhU};
        3'd4:    e = '{en: EnVW, hi: PhW, lo: PhV};
        default: e = '{en: EnUV, hi: PhU, lo: PhV};
      endcase
    end else begin
      case (sector)
        3'd0:    e = '{en: EnVW, hi: PhV, lo: PhW};
        3'd1:    e = '{en: EnUV, hi: PhV, lo: PhU};
        3'd2:    e = '{en: EnUW, hi: PhW, lo: PhU};
        3'd3:    e = '{en: EnVW, hi: PhW, lo: PhV};
        3'd4:    e = '{en: EnUV, hi: PhU, lo: PhV};
        default: e = '{en: EnUW, hi: PhU, lo: PhW};
      endcase
    end
    return e;
  endfunction

endpackage

### src/bldc_hall_commutation.sv
// Top level of the hall-sensor BLDC commutation block.
//
//  port group   | direction | contents
//  s_axis_*     | in        | one item: hall sample or angle update
//  m_axis_*     | out       | one result per item: compares, enables, status
//  APB          | in/out    | duty_level, direction, sine_mode registers
//
// An item is registered at the input, then decoded into the result register;
// one item is taken every cycle while the output is not stalled, limited by the
// single combinational pass through the sine table and the three 8x16 multipliers.
// Reset zeroes the config registers, valid flags, angle, compares, enables, code
// and count (input data and hall_error are not reset). A stalled output holds its
// result; the input register keeps taking items as long as the result register can move.
module bldc_hall_commutation (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // hall_bits[2:0], angle_value[11:3], zero pad
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // compare_u[7:0], compare_v[15:8], compare_w[23:16],
                                      // phase_enables[26:24], current_angle[35:27],
                                      // last_hall_code[38:36], hall_error[39],
                                      // invalid_total[55:40]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import bhc_pkg::*;

  // Configuration registers.
  logic [PwmBits-1:0] duty_q;
  logic               dir_q;
  logic               sine_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_q <= '0;
      dir_q  <= 1'b0;
      sine_q <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegDuty:      duty_q <= pwdata[PwmBits-1:0];
        RegDirection: dir_q  <= pwdata[0];
        RegSineMode:  sine_q <= pwdata[0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegDuty:      prdata = 32'(duty_q);
      RegDirection: prdata = 32'(dir_q);
      RegSineMode:  prdata = 32'(sine_q);
      default:      prdata = '0;
    endcase
  end

  // Input register.
  logic                 in_v_q;
  logic                 kind_q;
  logic [HallBits-1:0]  hall_q;
  logic [AngleBits-1:0] aval_q;
  logic                 fire;

  assign fire          = in_v_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_v_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      hall_q <= s_axis_tdata[2:0];
      aval_q <= s_axis_tdata[11:3];
    end
  end

  // Block state.
  logic [AngleBits-1:0]    angle_q;
  cmp_arr_t                cmp_q;
  logic [2:0]              en_q;
  logic [HallBits-1:0]     code_q;
  logic [ErrCountBits-1:0] count_q;

  upd_t     upd;
  cmp_arr_t sine_cmp;
  cmp_arr_t cmp_d;
  logic [2:0] en_d;
  logic [2:0] sector;
  step_t    step;

  bhc_angle_update u_angle (
    .kind_i      (kind_q),
    .hall_i      (hall_q),
    .angle_val_i (aval_q),
    .angle_i     (angle_q),
    .code_i      (code_q),
    .count_i     (count_q),
    .upd_o       (upd)
  );

  bhc_sine_drive u_sine (
    .angle_i (upd.angle),
    .fwd_i   (dir_q),
    .duty_i  (duty_q),
    .cmp_o   (sine_cmp)
  );

  always_comb begin
    if (upd.angle < AngleBits'(60)) begin
      sector = 3'd0;
    end else if (upd.angle < AngleBits'(120)) begin
      sector = 3'd1;
    end else if (upd.angle < AngleBits'(180)) begin
      sector = 3'd2;
    end else if (upd.angle < AngleBits'(240)) begin
      sector = 3'd3;
    end else if (upd.angle < AngleBits'(300)) begin
      sector = 3'd4;
    end else begin
      sector = 3'd5;
    end
    step = step_entry(dir_q, sector);
  end

  always_comb begin
    cmp_d = cmp_q;
    if (sine_q) begin
      cmp_d = sine_cmp;
      en_d  = EnAll;
    end else begin
      // The phase that is neither driven high nor low keeps its compare.
      cmp_d[step.hi] = duty_q;
      cmp_d[step.lo] = '0;
      en_d           = step.en;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      cmp_q   <= '0;
      en_q    <= '0;
      code_q  <= '0;
      count_q <= '0;
    end else if (fire) begin
      angle_q <= upd.angle;
      cmp_q   <= cmp_d;
      en_q    <= en_d;
      code_q  <= upd.code;
      count_q <= upd.count;
    end
  end

  // Result register.
  logic out_v_q;
  logic err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      err_q <= upd.err;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {count_q, err_q, code_q, angle_q, en_q,
                          cmp_q[PhW], cmp_q[PhV], cmp_q[PhU]};

`ifndef NO_ASSERTIONS
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_q < AngleBits'(360))
    else $error("shaft angle out of range");

  a_err_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && err_q) |-> (count_q != '0))
    else $error("hall error reported with zero invalid count");

  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> m_axis_tvalid)
    else $error("processed item produced no result");

  a_ready_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_v_q && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without a pending item");
`endif

endmodule

### src/bhc_angle_update.sv
// Hall decoding, direct angle load and invalid-code counting.
module bhc_angle_update (
  input  logic                             kind_i,
  input  logic [bhc_pkg::HallBits-1:0]     hall_i,
  input  logic [bhc_pkg::AngleBits-1:0]    angle_val_i,
  input  logic [bhc_pkg::AngleBits-1:0]    angle_i,
  input  logic [bhc_pkg::HallBits-1:0]     code_i,
  input  logic [bhc_pkg::ErrCountBits-1:0] count_i,
  output bhc_pkg::upd_t                    upd_o
);
  import bhc_pkg::*;

  localparam logic [AngleBits-1:0] FullTurn = AngleBits'(360);

  logic                 hall_ok;
  logic [AngleBits-1:0] hall_deg;

  always_comb begin
    hall_ok  = 1'b1;
    hall_deg = '0;
    case (hall_i)
      Hall000: hall_deg = AngleBits'(0);
      Hall060: hall_deg = AngleBits'(60);
      Hall120: hall_deg = AngleBits'(120);
      Hall180: hall_deg = AngleBits'(180);
      Hall240: hall_deg = AngleBits'(240);
      Hall300: hall_deg = AngleBits'(300);
      default: hall_ok  = 1'b0;
    endcase
  end

  always_comb begin
    upd_o.angle = angle_i;
    upd_o.code  = code_i;
    upd_o.err   = 1'b0;
    upd_o.count = count_i;
    if (kind_i == KindAngle) begin
      upd_o.angle = (angle_val_i >= FullTurn) ? angle_val_i - FullTurn : angle_val_i;
    end else if (hall_ok) begin
      upd_o.angle = hall_deg;
      upd_o.code  = hall_i;
    end else begin
      upd_o.err = 1'b1;
      if (count_i != '1) begin
        upd_o.count = count_i + ErrCountBits'(1);
      end
    end
  end

endmodule

### src/bhc_sine_drive.sv
// Sinusoidal compares for the three phases from the shaft angle.
module bhc_sine_drive (
  input  logic [bhc_pkg::AngleBits-1:0] angle_i,
  input  logic                          fwd_i,
  input  logic [bhc_pkg::PwmBits-1:0]   duty_i,
  output bhc_pkg::cmp_arr_t             cmp_o
);
  import bhc_pkg::*;

  localparam int VBits    = SineFracBits + 1;
  localparam int ProdBits = PwmBits + VBits + 1;

  logic [2:0][AngleBits-1:0] deg;
  logic [AngleBits-1:0]      minus_deg;
  logic [AngleBits-1:0]      plus_deg;

  assign minus_deg = (angle_i >= AngleBits'(120)) ? angle_i - AngleBits'(120)
                                                  : angle_i + AngleBits'(240);
  assign plus_deg  = (angle_i >= AngleBits'(240)) ? angle_i - AngleBits'(240)
                                                  : angle_i + AngleBits'(120);

  assign deg[PhU] = angle_i;
  assign deg[PhV] = fwd_i ? minus_deg : plus_deg;
  assign deg[PhW] = fwd_i ? plus_deg : minus_deg;

  always_comb begin
    logic [AngleBits-1:0]    folded;
    logic                    neg;
    logic [SineFracBits-1:0] mag;
    logic [VBits-1:0]        v;
    logic [ProdBits-1:0]     prod;
    logic [ProdBits-1:0]     shifted;
    for (int p = 0; p < 3; p++) begin
      // Fold the angle onto the first quarter wave.
      neg    = 1'b0;
      folded = deg[p];
      if (deg[p] <= AngleBits'(90)) begin
        folded = deg[p];
      end else if (deg[p] <= AngleBits'(180)) begin
        folded = AngleBits'(180) - deg[p];
      end else if (deg[p] <= AngleBits'(270)) begin
        folded = deg[p] - AngleBits'(180);
        neg    = 1'b1;
      end else begin
        folded = AngleBits'(360) - deg[p];
        neg    = 1'b1;
      end
      mag = SineTable[folded[SineIdxBits-1:0]];
      v   = neg ? (VBits'(1) << SineFracBits) - VBits'(mag)
                : (VBits'(1) << SineFracBits) + VBits'(mag);
      prod = ProdBits'(duty_i) * ProdBits'(v) + (ProdBits'(1) << SineFracBits);
      shifted = prod >> (SineFracBits + 1);
      if (shifted > ProdBits'({PwmBits{1'b1}})) begin
        cmp_o[p] = '1;
      end else begin
        cmp_o[p] = shifted[PwmBits-1:0];
      end
    end
  end

endmodule
